// File: src/msgpack_object_skipper_core_macros.svh
// ----------------------------------------------------------------------------
// MessagePack object skipper - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef MSGPACK_OBJECT_SKIPPER_CORE_MACROS_SVH
`define MSGPACK_OBJECT_SKIPPER_CORE_MACROS_SVH

// same-cycle implication
`define MOS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MOS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/mos_pkg.sv
// ----------------------------------------------------------------------------
// mos_pkg
// Constants, codes and shared types of the MessagePack object skipper.
// ----------------------------------------------------------------------------
package mos_pkg;

  localparam int MAX_NESTING = 8;
  localparam int LVL_W       = $clog2(MAX_NESTING + 1);
  localparam int IDX_W       = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
  localparam int CNT_W       = 33;
  localparam int LEFT_W      = 32;
  localparam int LEN_W       = 32;

  typedef logic [CNT_W-1:0] count_t;

  // reported status
  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
  localparam logic [1:0] STATUS_DEEP    = 2'd2;
  localparam logic [1:0] STATUS_TRUNC   = 2'd3;

  // internal step outcome; low codes match the reported status
  localparam logic [2:0] STEP_DONE    = 3'd0;
  localparam logic [2:0] STEP_UNKNOWN = 3'd1;
  localparam logic [2:0] STEP_DEEP    = 3'd2;
  localparam logic [2:0] STEP_TRUNC   = 3'd3;
  localparam logic [2:0] STEP_MORE    = 3'd4;
  localparam logic [2:0] STEP_ELEM    = 3'd5;

  // kind of a multi-byte length/count header
  localparam logic [1:0] KIND_STRBIN = 2'd0;
  localparam logic [1:0] KIND_EXT    = 2'd1;
  localparam logic [1:0] KIND_ARRAY  = 2'd2;
  localparam logic [1:0] KIND_MAP    = 2'd3;

  typedef enum logic [2:0] {
    ACT_MORE,
    ACT_ELEM,
    ACT_PAYLOAD,
    ACT_OPEN,
    ACT_HEADER,
    ACT_UNKNOWN
  } act_t;

  typedef struct packed {
    act_t       act;
    logic [4:0] size;       // payload length or element count (maps doubled)
    logic [2:0] hdr_bytes;
    logic [1:0] hdr_kind;
  } tag_info_t;

  typedef struct packed {
    logic   clear;
    logic   push;
    logic   pop;
    count_t push_count;
  } stack_cmd_t;

  typedef struct packed {
    logic full;       // no room for another open container
    logic pop_empty;  // a pop would close every open container
  } stack_stat_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [LEN_W-1:0] object_bytes;
  } result_t;

endpackage

// File: src/mos_byte_if.sv
// ----------------------------------------------------------------------------
// mos_byte_if
// Byte stream channel: one encoded byte and the bytes left after it.
// ----------------------------------------------------------------------------
interface mos_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [31:0] bytes_left;

  modport source (output valid, output data_byte, output bytes_left, input ready);
  modport sink   (input valid, input data_byte, input bytes_left, output ready);
endinterface

// File: src/mos_result_if.sv
// ----------------------------------------------------------------------------
// mos_result_if
// Result channel: outcome of one object walk and its byte length.
// ----------------------------------------------------------------------------
interface mos_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] object_bytes;

  modport source (output valid, output status, output object_bytes, input ready);
  modport sink   (input valid, input status, input object_bytes, output ready);
endinterface

// File: src/msgpack_object_skipper_core.sv
// ----------------------------------------------------------------------------
// msgpack_object_skipper_core
// Streaming MessagePack structure walk: one byte per item, one result per
// complete object or error.
//
//   channel   dir   payload                        handshake
//   stream    in    data_byte[8], bytes_left[32]   valid/ready
//   verdict   out   status[2], object_bytes[32]    valid/ready
//
// One byte per cycle while the result queue has room. An item is walked in the
// input register, and its result (if any) is in the result queue next cycle.
// The per-cycle limit is the walk path: tag decode, a 33-bit length compare
// and the priority pop over the level registers.
// Reset (rst, synchronous) empties the input register, the queue and the stack
// and clears the walk state; no clearing pass is needed.
// stream.ready comes from registers only: it drops when the input register is
// full and the two-entry queue has no room.
// ----------------------------------------------------------------------------
module msgpack_object_skipper_core (
  input  logic         clk,
  input  logic         rst,
  mos_byte_if.sink     stream,
  mos_result_if.source verdict
);
  import mos_pkg::*;

  // input register
  logic              stage_valid;
  logic [7:0]        stage_byte;
  logic [LEFT_W-1:0] stage_left;

  // walk state
  count_t            payload_remaining;
  count_t            payload_remaining_next;
  logic [2:0]        header_pending;
  logic [2:0]        header_pending_next;
  logic [31:0]       header_acc;
  logic [31:0]       header_acc_next;
  logic [1:0]        header_kind;
  logic [1:0]        header_kind_next;
  logic              discarding;
  logic              discarding_next;
  logic [LEN_W-1:0]  object_length;
  logic [LEN_W-1:0]  object_length_next;

  logic              q_space;
  logic              step;
  logic              accept;
  logic              emit;
  logic [2:0]        code;
  logic [LEN_W-1:0]  length_inc;
  logic [31:0]       acc_shift;
  count_t            left_ext;

  act_t              act;
  count_t            amount;
  logic              check;
  logic [2:0]        hdr_bytes;
  logic [1:0]        hdr_kind;

  tag_info_t         tag_info;
  stack_cmd_t        cmd_raw;
  stack_cmd_t        stack_cmd;
  stack_stat_t       stack_stat;
  result_t           result;

  // --- handshake ------------------------------------------------------------
  assign step         = stage_valid && q_space;
  assign stream.ready = !stage_valid || q_space;
  assign accept       = stream.valid && stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (step) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_byte <= stream.data_byte;
      stage_left <= stream.bytes_left;
    end
  end

  // --- tag classification and nesting stack ---------------------------------
  mos_tag_decode u_tag_decode (
    .tag  (stage_byte),
    .info (tag_info)
  );

  assign stack_cmd = step ? cmd_raw : '0;

  mos_level_stack u_level_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (stack_cmd),
    .stat (stack_stat)
  );

  // --- walk of the byte in the input register -------------------------------
  assign length_inc = (object_length == '1) ? object_length : object_length + LEN_W'(1);
  assign acc_shift  = {header_acc[23:0], stage_byte};
  assign left_ext   = {1'b0, stage_left};

  // pick what this byte does: payload byte, length header byte or a new tag
  always_comb begin
    payload_remaining_next = payload_remaining;
    header_pending_next    = header_pending;
    header_acc_next        = header_acc;
    act                    = ACT_MORE;
    amount                 = '0;
    check                  = 1'b0;
    hdr_bytes              = tag_info.hdr_bytes;
    hdr_kind               = tag_info.hdr_kind;

    if (payload_remaining != '0) begin
      payload_remaining_next = payload_remaining - count_t'(1);
      act = (payload_remaining == count_t'(1)) ? ACT_ELEM : ACT_MORE;
    end else if (header_pending != 3'd0) begin
      header_acc_next     = acc_shift;
      header_pending_next = header_pending - 3'd1;
      if (header_pending == 3'd1) begin
        // last header byte: length/count is complete
        unique case (header_kind)
          KIND_STRBIN: begin
            act    = ACT_PAYLOAD;
            amount = {1'b0, acc_shift};
          end
          KIND_EXT: begin
            act    = ACT_PAYLOAD;
            amount = {1'b0, acc_shift} + count_t'(1);  // type byte
          end
          KIND_ARRAY: begin
            act    = ACT_OPEN;
            amount = {1'b0, acc_shift};
            check  = 1'b1;
          end
          KIND_MAP: begin
            act    = ACT_OPEN;
            amount = {acc_shift, 1'b0};  // key and value per entry
            check  = 1'b1;
          end
        endcase
      end
    end else begin
      act    = tag_info.act;
      amount = count_t'(tag_info.size);
    end
  end

  // resolve into a step outcome and the register updates
  always_comb begin
    header_kind_next = header_kind;
    cmd_raw          = '0;
    cmd_raw.push_count = amount;
    code             = STEP_MORE;

    unique case (act)
      ACT_MORE: code = STEP_MORE;
      ACT_ELEM: code = STEP_ELEM;
      ACT_PAYLOAD: begin
        if (amount > left_ext) begin
          code = STEP_TRUNC;
        end else if (amount == '0) begin
          code = STEP_ELEM;
        end else begin
          code = STEP_MORE;
        end
      end
      ACT_OPEN: begin
        // fixarray/fixmap counts skip the bytes-left check
        if (check && amount > left_ext) begin
          code = STEP_TRUNC;
        end else if (amount == '0) begin
          code = STEP_ELEM;  // empty container counts as one element
        end else if (stack_stat.full) begin
          code = STEP_DEEP;
        end else begin
          code = STEP_MORE;
          cmd_raw.push = 1'b1;
        end
      end
      ACT_HEADER: begin
        if (LEFT_W'(hdr_bytes) > stage_left) begin
          code = STEP_TRUNC;
        end else begin
          code             = STEP_MORE;
          header_kind_next = hdr_kind;
        end
      end
      ACT_UNKNOWN: code = STEP_UNKNOWN;
      default:     code = STEP_UNKNOWN;
    endcase

    // an element finished: close every container it completes
    if (code == STEP_ELEM) begin
      cmd_raw.pop = 1'b1;
      code = stack_stat.pop_empty ? STEP_DONE : STEP_MORE;
    end
    if (code == STEP_MORE && stage_left == '0) begin
      code = STEP_TRUNC;  // buffer ended mid-object
    end
    // a result empties the stack; dropped bytes keep it cleared
    cmd_raw.clear = discarding || (code != STEP_MORE);
  end

  // final register values, with clearing on result and the discard mode
  logic [2:0] pending_set;
  logic       acc_clear;

  assign pending_set = (act == ACT_HEADER && code == STEP_MORE) ? hdr_bytes : 3'd0;
  assign acc_clear   = (act == ACT_HEADER && code == STEP_MORE);

  count_t     payload_walk;
  logic [2:0] pending_walk;

  always_comb begin
    payload_walk = (act == ACT_PAYLOAD && code == STEP_MORE) ? amount
                                                            : payload_remaining_next;
    pending_walk = acc_clear ? pending_set : header_pending_next;
  end

  assign emit = !discarding && (code != STEP_MORE);

  logic [2:0]  pending_final;
  logic [31:0] acc_final;
  count_t      payload_final;
  logic [1:0]  kind_final;

  always_comb begin
    payload_final      = payload_walk;
    pending_final      = pending_walk;
    acc_final          = acc_clear ? 32'd0 : header_acc_next;
    kind_final         = header_kind_next;
    object_length_next = length_inc;
    discarding_next    = 1'b0;
    if (code != STEP_MORE) begin
      // result given: start over on the next object
      payload_final      = '0;
      pending_final      = 3'd0;
      acc_final          = 32'd0;
      kind_final         = KIND_STRBIN;
      object_length_next = '0;
      discarding_next    = (code != STEP_DONE) && (stage_left != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_remaining <= '0;
      header_pending    <= 3'd0;
      header_acc        <= 32'd0;
      header_kind       <= KIND_STRBIN;
      discarding        <= 1'b0;
      object_length     <= '0;
    end else if (step) begin
      if (discarding) begin
        // drop bytes until the last one of the buffer
        discarding <= (stage_left != '0);
      end else begin
        payload_remaining <= payload_final;
        header_pending    <= pending_final;
        header_acc        <= acc_final;
        header_kind       <= kind_final;
        discarding        <= discarding_next;
        object_length     <= object_length_next;
      end
    end
  end

  // --- result queue ---------------------------------------------------------
  assign result.status       = code[1:0];
  assign result.object_bytes = length_inc;

  mos_result_queue u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (step && emit),
    .wdata (result),
    .space (q_space),
    .res   (verdict)
  );

endmodule

// File: src/mos_tag_decode.sv
// ----------------------------------------------------------------------------
// mos_tag_decode
// Classifies a MessagePack tag byte into the action it starts.
// ----------------------------------------------------------------------------
module mos_tag_decode (
  input  logic [7:0]         tag,
  output mos_pkg::tag_info_t info
);
  import mos_pkg::*;

  localparam logic [7:0] POS_FIXINT_MAX = 8'h7f;
  localparam logic [7:0] NEG_FIXINT_MIN = 8'he0;
  localparam logic [7:0] FIXSTR_MASK    = 8'he0;
  localparam logic [7:0] FIXSTR_BASE    = 8'ha0;
  localparam logic [7:0] FIXCNT_MASK    = 8'hf0;
  localparam logic [7:0] FIXARRAY_BASE  = 8'h90;
  localparam logic [7:0] FIXMAP_BASE    = 8'h80;

  localparam logic [7:0] TAG_NIL      = 8'hc0;
  localparam logic [7:0] TAG_FALSE    = 8'hc2;
  localparam logic [7:0] TAG_TRUE     = 8'hc3;
  localparam logic [7:0] TAG_BIN8     = 8'hc4;
  localparam logic [7:0] TAG_BIN16    = 8'hc5;
  localparam logic [7:0] TAG_BIN32    = 8'hc6;
  localparam logic [7:0] TAG_EXT8     = 8'hc7;
  localparam logic [7:0] TAG_EXT16    = 8'hc8;
  localparam logic [7:0] TAG_EXT32    = 8'hc9;
  localparam logic [7:0] TAG_FLOAT32  = 8'hca;
  localparam logic [7:0] TAG_FLOAT64  = 8'hcb;
  localparam logic [7:0] TAG_UINT8    = 8'hcc;
  localparam logic [7:0] TAG_UINT16   = 8'hcd;
  localparam logic [7:0] TAG_UINT32   = 8'hce;
  localparam logic [7:0] TAG_UINT64   = 8'hcf;
  localparam logic [7:0] TAG_INT8     = 8'hd0;
  localparam logic [7:0] TAG_INT16    = 8'hd1;
  localparam logic [7:0] TAG_INT32    = 8'hd2;
  localparam logic [7:0] TAG_INT64    = 8'hd3;
  localparam logic [7:0] TAG_FIXEXT1  = 8'hd4;
  localparam logic [7:0] TAG_FIXEXT2  = 8'hd5;
  localparam logic [7:0] TAG_FIXEXT4  = 8'hd6;
  localparam logic [7:0] TAG_FIXEXT8  = 8'hd7;
  localparam logic [7:0] TAG_FIXEXT16 = 8'hd8;
  localparam logic [7:0] TAG_STR8     = 8'hd9;
  localparam logic [7:0] TAG_STR16    = 8'hda;
  localparam logic [7:0] TAG_STR32    = 8'hdb;
  localparam logic [7:0] TAG_ARRAY16  = 8'hdc;
  localparam logic [7:0] TAG_ARRAY32  = 8'hdd;
  localparam logic [7:0] TAG_MAP16    = 8'hde;
  localparam logic [7:0] TAG_MAP32    = 8'hdf;

  always_comb begin
    info           = '0;
    info.act       = ACT_UNKNOWN;
    info.hdr_kind  = KIND_STRBIN;
    priority if (tag <= POS_FIXINT_MAX || tag >= NEG_FIXINT_MIN) begin
      info.act = ACT_ELEM;
    end else if ((tag & FIXSTR_MASK) == FIXSTR_BASE) begin
      info.act  = ACT_PAYLOAD;
      info.size = tag[4:0];
    end else if ((tag & FIXCNT_MASK) == FIXARRAY_BASE) begin
      info.act  = ACT_OPEN;
      info.size = {1'b0, tag[3:0]};
    end else if ((tag & FIXCNT_MASK) == FIXMAP_BASE) begin
      info.act  = ACT_OPEN;
      info.size = {tag[3:0], 1'b0};
    end else begin
      unique case (tag)
        TAG_NIL, TAG_FALSE, TAG_TRUE: info.act = ACT_ELEM;
        TAG_UINT8, TAG_INT8: begin
          info.act = ACT_PAYLOAD; info.size = 5'd1;
        end
        TAG_UINT16, TAG_INT16, TAG_FIXEXT1: begin
          info.act = ACT_PAYLOAD; info.size = 5'd2;
        end
        TAG_FIXEXT2: begin
          info.act = ACT_PAYLOAD; info.size = 5'd3;
        end
        TAG_FLOAT32, TAG_UINT32, TAG_INT32: begin
          info.act = ACT_PAYLOAD; info.size = 5'd4;
        end
        TAG_FIXEXT4: begin
          info.act = ACT_PAYLOAD; info.size = 5'd5;
        end
        TAG_FLOAT64, TAG_UINT64, TAG_INT64: begin
          info.act = ACT_PAYLOAD; info.size = 5'd8;
        end
        TAG_FIXEXT8: begin
          info.act = ACT_PAYLOAD; info.size = 5'd9;
        end
        TAG_FIXEXT16: begin
          info.act = ACT_PAYLOAD; info.size = 5'd17;
        end
        TAG_BIN8, TAG_STR8: begin
          info.act = ACT_HEADER; info.hdr_bytes = 3'd1; info.hdr_kind = KIND_STRBIN;
        end
        TAG_BIN16, TAG_STR16: begin
          info.act = ACT_HEADER; info.hdr_bytes = 3'd2; info.hdr_kind = KIND_STRBIN;
        end
        TAG_BIN32, TAG_STR32: begin
          info.act = ACT_HEADER; info.hdr_bytes = 3'd4; info.hdr_kind = KIND_STRBIN;
        end
        TAG_EXT8: begin
          info.act = ACT_HEADER; info.hdr_bytes = 3'd1; info.hdr_kind = KIND_EXT;
        end
        TAG_EXT16: begin
          info.act = ACT_HEADER; info.hdr_bytes = 3'd2; info.hdr_kind = KIND_EXT;
        end
        TAG_EXT32: begin
          info.act = ACT_HEADER; info.hdr_bytes = 3'd4; info.hdr_kind = KIND_EXT;
        end
        TAG_ARRAY16: begin
          info.act = ACT_HEADER; info.hdr_bytes = 3'd2; info.hdr_kind = KIND_ARRAY;
        end
        TAG_ARRAY32: begin
          info.act = ACT_HEADER; info.hdr_bytes = 3'd4; info.hdr_kind = KIND_ARRAY;
        end
        TAG_MAP16: begin
          info.act = ACT_HEADER; info.hdr_bytes = 3'd2; info.hdr_kind = KIND_MAP;
        end
        TAG_MAP32: begin
          info.act = ACT_HEADER; info.hdr_bytes = 3'd4; info.hdr_kind = KIND_MAP;
        end
        default: info.act = ACT_UNKNOWN;  // the never-used tag
      endcase
    end
  end

endmodule

// File: src/mos_level_stack.sv
// ----------------------------------------------------------------------------
// mos_level_stack
// Stack of pending element counts, one register per nesting level.
// ----------------------------------------------------------------------------
module mos_level_stack (
  input  logic                 clk,
  input  logic                 rst,
  input  mos_pkg::stack_cmd_t  cmd,
  output mos_pkg::stack_stat_t stat
);
  import mos_pkg::*;

  count_t           counts [MAX_NESTING];
  logic [LVL_W-1:0] level;
  logic [IDX_W-1:0] keep_idx;
  logic             keep_found;

  // highest open level whose count is not one survives a pop; all above it close
  always_comb begin
    keep_found = 1'b0;
    keep_idx   = '0;
    for (int i = 0; i < MAX_NESTING; i++) begin
      if (LVL_W'(i) < level && counts[i] != count_t'(1)) begin
        keep_found = 1'b1;
        keep_idx   = IDX_W'(i);
      end
    end
  end

  assign stat.full      = (level >= LVL_W'(MAX_NESTING));
  assign stat.pop_empty = !keep_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (cmd.clear) begin
      level <= '0;
    end else if (cmd.push) begin
      level <= level + LVL_W'(1);
    end else if (cmd.pop) begin
      level <= keep_found ? (LVL_W'(keep_idx) + LVL_W'(1)) : '0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_NESTING; i++) begin
      if (!cmd.clear && cmd.push && level == LVL_W'(i)) begin
        counts[i] <= cmd.push_count;
      end else if (!cmd.clear && cmd.pop && keep_found && keep_idx == IDX_W'(i)) begin
        counts[i] <= counts[i] - count_t'(1);
      end
    end
  end

endmodule

// File: src/mos_result_queue.sv
// ----------------------------------------------------------------------------
// mos_result_queue
// Two-entry result queue; decouples output stalls from the input side.
// ----------------------------------------------------------------------------
module mos_result_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mos_pkg::result_t wdata,
  output logic             space,
  mos_result_if.source     res
);
  import mos_pkg::*;

  result_t    entries [2];
  logic       wr_sel;
  logic       rd_sel;
  logic [1:0] fill;
  logic       pop;

  assign pop              = res.valid && res.ready;
  assign res.valid        = (fill != 2'd0);
  assign res.status       = entries[rd_sel].status;
  assign res.object_bytes = entries[rd_sel].object_bytes;
  assign space            = (fill != 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_sel <= ~wr_sel;
      if (pop)  rd_sel <= ~rd_sel;
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_sel] <= wdata;
  end

endmodule

// File: src/mos_checker.sv
// ----------------------------------------------------------------------------
// mos_checker
// Port-level checks on the object skipper, bound to the top level.
// ----------------------------------------------------------------------------
`include "msgpack_object_skipper_core_macros.svh"

module mos_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [31:0] object_bytes
);
  import mos_pkg::*;

  logic in_seen;
  assign in_seen = in_valid;

  `MOS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result withdrawn while stalled")
  `MOS_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(status) && $stable(object_bytes), "stalled result changed")
  // an empty result queue always leaves room for a new byte
  `MOS_ASSERT_IMP(a_ready_when_drained, !out_valid && (in_seen || !in_seen), in_ready, "input stalled with no result pending")
  // too deep needs more nested headers than the stack holds
  `MOS_ASSERT_IMP(a_deep_length, out_valid && status == STATUS_DEEP, object_bytes > 32'(MAX_NESTING), "depth error on a short object")

endmodule

bind msgpack_object_skipper_core mos_checker u_mos_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (stream.valid),
  .in_ready     (stream.ready),
  .out_valid    (verdict.valid),
  .out_ready    (verdict.ready),
  .status       (verdict.status),
  .object_bytes (verdict.object_bytes)
);

// File: verif/mos_tag_pkg.sv
// ----------------------------------------------------------------------------
// mos_tag_pkg
// MessagePack tag bytes and tag-family masks shared by the skipper testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package mos_tag_pkg;

  // single-byte families
  localparam logic [7:0] TAG_POSFIX_MAX   = 8'h7f;
  localparam logic [7:0] TAG_FIXMAP_BASE  = 8'h80;
  localparam logic [7:0] TAG_FIXARRAY_BASE = 8'h90;
  localparam logic [7:0] TAG_FIXSTR_BASE  = 8'ha0;
  localparam logic [7:0] TAG_NEGFIX_BASE  = 8'he0;

  localparam logic [7:0] TAG_FIXSTR_MASK  = 8'he0;
  localparam logic [7:0] TAG_FIXSTR_LEN   = 8'h1f;
  localparam logic [7:0] TAG_FIXCOL_MASK  = 8'hf0;
  localparam logic [7:0] TAG_FIXCOL_LEN   = 8'h0f;

  localparam logic [7:0] TAG_NIL          = 8'hc0;
  localparam logic [7:0] TAG_NEVER_USED   = 8'hc1;
  localparam logic [7:0] TAG_FALSE        = 8'hc2;
  localparam logic [7:0] TAG_TRUE         = 8'hc3;
  localparam logic [7:0] TAG_BIN8         = 8'hc4;
  localparam logic [7:0] TAG_BIN16        = 8'hc5;
  localparam logic [7:0] TAG_BIN32        = 8'hc6;
  localparam logic [7:0] TAG_EXT8         = 8'hc7;
  localparam logic [7:0] TAG_EXT16        = 8'hc8;
  localparam logic [7:0] TAG_EXT32        = 8'hc9;
  localparam logic [7:0] TAG_FLOAT32      = 8'hca;
  localparam logic [7:0] TAG_FLOAT64      = 8'hcb;
  localparam logic [7:0] TAG_UINT8        = 8'hcc;
  localparam logic [7:0] TAG_UINT16       = 8'hcd;
  localparam logic [7:0] TAG_UINT32       = 8'hce;
  localparam logic [7:0] TAG_UINT64       = 8'hcf;
  localparam logic [7:0] TAG_INT8         = 8'hd0;
  localparam logic [7:0] TAG_INT16        = 8'hd1;
  localparam logic [7:0] TAG_INT32        = 8'hd2;
  localparam logic [7:0] TAG_INT64        = 8'hd3;
  localparam logic [7:0] TAG_FIXEXT1      = 8'hd4;
  localparam logic [7:0] TAG_FIXEXT2      = 8'hd5;
  localparam logic [7:0] TAG_FIXEXT4      = 8'hd6;
  localparam logic [7:0] TAG_FIXEXT8      = 8'hd7;
  localparam logic [7:0] TAG_FIXEXT16     = 8'hd8;
  localparam logic [7:0] TAG_STR8         = 8'hd9;
  localparam logic [7:0] TAG_STR16        = 8'hda;
  localparam logic [7:0] TAG_STR32        = 8'hdb;
  localparam logic [7:0] TAG_ARRAY16      = 8'hdc;
  localparam logic [7:0] TAG_ARRAY32      = 8'hdd;
  localparam logic [7:0] TAG_MAP16        = 8'hde;
  localparam logic [7:0] TAG_MAP32        = 8'hdf;

endpackage

// File: verif/mos_skipper_checker.sv
// ----------------------------------------------------------------------------
// mos_skipper_checker
// Watches both channels, walks every accepted byte through its own model of
// the skipper and compares each verdict with the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mos_skipper_checker (
  input  logic  clk,
  input  logic  rst,
  mos_byte_if   stream,
  mos_result_if verdict,
  output int    fails,
  output int    pending,
  output int    walked
);
  import mos_pkg::*;
  import mos_tag_pkg::*;

  count_t           due_by_level [0:MAX_NESTING];
  logic [LVL_W-1:0] open_levels;
  count_t           payload_due;
  logic [2:0]       hdr_due;
  logic [31:0]      hdr_acc;
  logic [1:0]       hdr_kind;
  logic             skipping;
  logic [LEN_W-1:0] obj_len;
  result_t          verdicts_due [$];

  function automatic void clear_walk();
    for (int i = 0; i <= MAX_NESTING; i++) due_by_level[i] = '0;
    open_levels = '0;
    payload_due = '0;
    hdr_due     = '0;
    hdr_acc     = '0;
    hdr_kind    = KIND_STRBIN;
    obj_len     = '0;
  endfunction

  function automatic logic [2:0] start_payload(count_t n, logic [31:0] left);
    if (n > count_t'(left)) return STEP_TRUNC;
    if (n == '0) return STEP_ELEM;
    payload_due = n;
    return STEP_MORE;
  endfunction

  function automatic logic [2:0] start_header(logic [2:0] k, logic [1:0] kind,
                                               logic [31:0] left);
    if (32'(k) > left) return STEP_TRUNC;
    hdr_due  = k;
    hdr_acc  = '0;
    hdr_kind = kind;
    return STEP_MORE;
  endfunction

  function automatic logic [2:0] open_level(count_t n, logic [31:0] left, bit checked);
    if (checked && n > count_t'(left)) return STEP_TRUNC;
    if (n == '0) return STEP_ELEM;
    if (open_levels >= MAX_NESTING) return STEP_DEEP;
    due_by_level[open_levels] = n;
    open_levels = open_levels + 1'b1;
    return STEP_MORE;
  endfunction

  // one element finished: count it off and close every container it fills
  function automatic logic [2:0] close_levels();
    while (open_levels != 0) begin
      if (due_by_level[open_levels - 1'b1] != '0)
        due_by_level[open_levels - 1'b1] = due_by_level[open_levels - 1'b1] - 1'b1;
      if (due_by_level[open_levels - 1'b1] != '0) return STEP_MORE;
      open_levels = open_levels - 1'b1;
    end
    return STEP_DONE;
  endfunction

  function automatic logic [2:0] end_header(logic [31:0] left);
    case (hdr_kind)
      KIND_STRBIN: return start_payload(count_t'(hdr_acc), left);
      KIND_EXT:    return start_payload(count_t'(hdr_acc) + 1'b1, left);
      KIND_ARRAY:  return open_level(count_t'(hdr_acc), left, 1'b1);
      default:     return open_level({hdr_acc, 1'b0}, left, 1'b1);
    endcase
  endfunction

  function automatic logic [2:0] decode_tag(logic [7:0] b, logic [31:0] left);
    if (b <= TAG_POSFIX_MAX || b >= TAG_NEGFIX_BASE) return STEP_ELEM;
    if ((b & TAG_FIXSTR_MASK) == TAG_FIXSTR_BASE)
      return start_payload(count_t'(b & TAG_FIXSTR_LEN), left);
    if ((b & TAG_FIXCOL_MASK) == TAG_FIXARRAY_BASE)
      return open_level(count_t'(b & TAG_FIXCOL_LEN), left, 1'b0);
    if ((b & TAG_FIXCOL_MASK) == TAG_FIXMAP_BASE)
      return open_level(count_t'({b & TAG_FIXCOL_LEN, 1'b0}), left, 1'b0);
    case (b)
      TAG_NIL, TAG_FALSE, TAG_TRUE:         return STEP_ELEM;
      TAG_UINT8, TAG_INT8:                  return start_payload(1, left);
      TAG_UINT16, TAG_INT16:                return start_payload(2, left);
      TAG_FLOAT32, TAG_UINT32, TAG_INT32:   return start_payload(4, left);
      TAG_FLOAT64, TAG_UINT64, TAG_INT64:   return start_payload(8, left);
      TAG_FIXEXT1:                          return start_payload(2, left);
      TAG_FIXEXT2:                          return start_payload(3, left);
      TAG_FIXEXT4:                          return start_payload(5, left);
      TAG_FIXEXT8:                          return start_payload(9, left);
      TAG_FIXEXT16:                         return start_payload(17, left);
      TAG_BIN8, TAG_STR8:                   return start_header(1, KIND_STRBIN, left);
      TAG_BIN16, TAG_STR16:                 return start_header(2, KIND_STRBIN, left);
      TAG_BIN32, TAG_STR32:                 return start_header(4, KIND_STRBIN, left);
      TAG_EXT8:                             return start_header(1, KIND_EXT, left);
      TAG_EXT16:                            return start_header(2, KIND_EXT, left);
      TAG_EXT32:                            return start_header(4, KIND_EXT, left);
      TAG_ARRAY16:                          return start_header(2, KIND_ARRAY, left);
      TAG_ARRAY32:                          return start_header(4, KIND_ARRAY, left);
      TAG_MAP16:                            return start_header(2, KIND_MAP, left);
      TAG_MAP32:                            return start_header(4, KIND_MAP, left);
      default:                              return STEP_UNKNOWN;
    endcase
  endfunction

  // walk one byte; returns 1 with the verdict when the byte ends an object or an error is found
  function automatic bit walk_byte(logic [7:0] b, logic [31:0] left, output result_t res);
    logic [2:0] code;
    res = '0;
    if (skipping) begin
      if (left == 0) skipping = 1'b0;
      return 1'b0;
    end
    walked++;
    if (obj_len != '1) obj_len = obj_len + 1'b1;

    if (payload_due != '0) begin
      payload_due = payload_due - 1'b1;
      code = (payload_due == '0) ? STEP_ELEM : STEP_MORE;
    end else if (hdr_due != '0) begin
      hdr_acc = {hdr_acc[23:0], b};
      hdr_due = hdr_due - 1'b1;
      code = (hdr_due == '0) ? end_header(left) : STEP_MORE;
    end else begin
      code = decode_tag(b, left);
    end

    if (code == STEP_ELEM) code = close_levels();
    if (code == STEP_MORE && left == 0) code = STEP_TRUNC;
    if (code == STEP_MORE) return 1'b0;

    res.status       = code[1:0];
    res.object_bytes = obj_len;
    clear_walk();
    if (code != STEP_DONE && left != 0) skipping = 1'b1;
    return 1'b1;
  endfunction

  function automatic void flag(string msg);
    fails++;
    if (fails <= 10) $display("verdict mismatch: %s", msg);
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    result_t seen;
    if (rst) begin
      clear_walk();
      skipping = 1'b0;
      verdicts_due.delete();
      pending = 0;
    end else begin
      // compare first: a byte taken at this edge cannot have caused a verdict yet
      if (verdict.valid && verdict.ready) begin
        seen.status       = verdict.status;
        seen.object_bytes = verdict.object_bytes;
        if (verdicts_due.size() == 0) begin
          flag($sformatf("none due, got status %0d, %0d bytes",
                         seen.status, seen.object_bytes));
        end else begin
          want = verdicts_due.pop_front();
          if (seen.status !== want.status)
            flag($sformatf("status expected %0d, got %0d",
                           want.status, seen.status));
          if (seen.object_bytes !== want.object_bytes)
            flag($sformatf("object_bytes expected %0d, got %0d",
                           want.object_bytes, seen.object_bytes));
        end
      end
      if (stream.valid && stream.ready) begin
        if (walk_byte(stream.data_byte, stream.bytes_left, want))
          verdicts_due.push_back(want);
      end
      pending = verdicts_due.size();
    end
  end

endmodule

// File: verif/msgpack_object_skipper_core_test.sv
// ----------------------------------------------------------------------------
// msgpack_object_skipper_core_test
// Drives MessagePack buffers into the object skipper: a directed set of edge
// cases, then random buffers built from well-formed objects, some of them cut
// short, corrupted or replaced by noise. A checker beside the block predicts
// and compares every verdict; this module only makes traffic and decides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module msgpack_object_skipper_core_test;
  import mos_pkg::*;
  import mos_tag_pkg::*;

  localparam int RANDOM_BYTES = 340;   // walked bytes in the random part
  localparam int STALL_LIMIT  = 4000;  // cycles with no handshake at all
  localparam int DRAIN_CYCLES = 8;     // input register plus result queue, with margin

  logic clk;
  logic rst;

  mos_byte_if   stream_ch ();
  mos_result_if verdict_ch ();

  int fails;
  int pending;
  int walked;
  int phase = 0;  // 0 no idling, 1 sender idle, 2 receiver stalls, 3 both
  int quiet;

  logic [7:0]  buf_q [$];
  logic [31:0] extra;
  int          mode;
  int          base;
  int          n;

  msgpack_object_skipper_core uut (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream_ch),
    .verdict (verdict_ch)
  );

  mos_skipper_checker verdict_check (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream_ch),
    .verdict (verdict_ch),
    .fails   (fails),
    .pending (pending),
    .walked  (walked)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic bit chance(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic int idle_pct();
    case (phase)
      1:       return 86;
      3:       return 27;
      default: return 0;
    endcase
  endfunction

  function automatic int stall_pct();
    case (phase)
      2:       return 86;
      3:       return 27;
      default: return 0;
    endcase
  endfunction

  // receiver side: ready is redrawn at every falling edge
  always @(negedge clk) begin
    verdict_ch.ready = !chance(stall_pct());
  end

  // watchdog: a hung handshake ends the run
  always @(posedge clk) begin
    if (rst || (stream_ch.valid && stream_ch.ready) ||
        (verdict_ch.valid && verdict_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d verdicts due", quiet, pending);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // One byte: optional idle gap, then hold valid until the block takes it.
  // valid is only dropped at a gap, so it never goes low and high in one step.
  task automatic send_byte(input logic [7:0] b, input logic [31:0] left);
    @(negedge clk);
    while (chance(idle_pct())) begin
      stream_ch.valid = 1'b0;
      @(negedge clk);
    end
    stream_ch.valid      = 1'b1;
    stream_ch.data_byte  = b;
    stream_ch.bytes_left = left;
    do @(posedge clk); while (!stream_ch.ready);
  endtask

  // bytes_left counts down to extra; extra 0 closes the buffer on its last byte
  task automatic send_buffer(input logic [7:0] q [$], input logic [31:0] extra_left);
    foreach (q[i]) send_byte(q[i], extra_left + 32'(q.size() - 1 - i));
  endtask

  function automatic void put_be(ref logic [7:0] q [$], input logic [31:0] v, input int nb);
    for (int i = nb - 1; i >= 0; i--) q.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_noise(ref logic [7:0] q [$], input int nb);
    repeat (nb) q.push_back(8'($urandom_range(255, 0)));
  endfunction

  // Append one well-formed object with random content. Deep nesting is
  // reached by a chain of one-element arrays; past the stack limit, or once
  // the buffer is big enough, only scalars are added.
  function automatic void add_object(ref logic [7:0] q [$], input int depth);
    logic [7:0] num_tag [10] = '{TAG_UINT8, TAG_UINT16, TAG_UINT32, TAG_UINT64,
                                 TAG_INT8, TAG_INT16, TAG_INT32, TAG_INT64,
                                 TAG_FLOAT32, TAG_FLOAT64};
    int         num_len [10] = '{1, 2, 4, 8, 1, 2, 4, 8, 4, 8};
    logic [7:0] fx_tag [5]   = '{TAG_FIXEXT1, TAG_FIXEXT2, TAG_FIXEXT4,
                                 TAG_FIXEXT8, TAG_FIXEXT16};
    int         fx_len [5]   = '{2, 3, 5, 9, 17};
    int pick;
    int cnt;
    int k;
    int wide;
    int top;

    pick = (depth >= MAX_NESTING + 1 || q.size() > 40) ? $urandom_range(8, 0)
                                                       : $urandom_range(15, 0);
    wide = $urandom_range(1, 0);
    top  = (depth < 2) ? 4 : 2;
    case (pick)
      0: q.push_back(8'($urandom_range(127, 0)));
      1: q.push_back(8'($urandom_range(255, 224)));
      2: begin
        k = $urandom_range(2, 0);
        q.push_back(k == 0 ? TAG_NIL : (k == 1 ? TAG_FALSE : TAG_TRUE));
      end
      3: begin
        k = $urandom_range(9, 0);
        q.push_back(num_tag[k]);
        put_noise(q, num_len[k]);
      end
      4: begin
        cnt = $urandom_range(31, 0);
        q.push_back(TAG_FIXSTR_BASE | 8'(cnt));
        put_noise(q, cnt);
      end
      5: begin
        cnt = $urandom_range(24, 0);
        q.push_back(wide ? TAG_STR8 : TAG_BIN8);
        put_be(q, cnt, 1);
        put_noise(q, cnt);
      end
      6: begin
        cnt = $urandom_range(16, 0);
        if ($urandom_range(1, 0)) begin
          q.push_back(wide ? TAG_STR16 : TAG_BIN16);
          put_be(q, cnt, 2);
        end else begin
          q.push_back(wide ? TAG_STR32 : TAG_BIN32);
          put_be(q, cnt, 4);
        end
        put_noise(q, cnt);
      end
      7: begin
        k = $urandom_range(4, 0);
        q.push_back(fx_tag[k]);
        put_noise(q, fx_len[k]);
      end
      8: begin
        // ext: length, then type byte, then the data
        cnt = $urandom_range(12, 0);
        k   = $urandom_range(2, 0);
        q.push_back(k == 0 ? TAG_EXT8 : (k == 1 ? TAG_EXT16 : TAG_EXT32));
        put_be(q, cnt, k == 0 ? 1 : (k == 1 ? 2 : 4));
        put_noise(q, cnt + 1);
      end
      9, 10: begin
        cnt = $urandom_range(top + 2, 0);
        q.push_back(TAG_FIXARRAY_BASE | 8'(cnt));
        repeat (cnt) add_object(q, depth + 1);
      end
      11: begin
        cnt = $urandom_range(top, 0);
        q.push_back(TAG_FIXMAP_BASE | 8'(cnt));
        repeat (2 * cnt) add_object(q, depth + 1);
      end
      12: begin
        cnt = $urandom_range(top, 0);
        q.push_back(wide ? TAG_ARRAY16 : TAG_ARRAY32);
        put_be(q, cnt, wide ? 2 : 4);
        repeat (cnt) add_object(q, depth + 1);
      end
      13: begin
        cnt = $urandom_range(top - 1, 0);
        q.push_back(wide ? TAG_MAP16 : TAG_MAP32);
        put_be(q, cnt, wide ? 2 : 4);
        repeat (2 * cnt) add_object(q, depth + 1);
      end
      14: begin
        // chain of single-element containers, around the nesting limit
        if (depth == 0) begin
          k = $urandom_range(MAX_NESTING + 2, MAX_NESTING - 2);
          repeat (k) q.push_back(TAG_FIXARRAY_BASE | 8'd1);
          add_object(q, depth + k);
        end else begin
          q.push_back(TAG_NIL);
        end
      end
      default: begin
        // empty containers complete as a single element
        k = $urandom_range(1, 0);
        q.push_back(k ? TAG_FIXARRAY_BASE : TAG_FIXMAP_BASE);
      end
    endcase
  endfunction

  // Directed edge cases, one short buffer each.
  task automatic directed_cases();
    logic [7:0] q [$];

    // fixint extremes, several objects in one buffer
    q = '{8'h00};
    send_buffer(q, 0);
    q = '{TAG_POSFIX_MAX, TAG_NEGFIX_BASE, 8'hff};
    send_buffer(q, 0);
    q = '{TAG_NIL, TAG_FALSE, TAG_TRUE};
    send_buffer(q, 0);

    // unknown tag: the rest of the buffer is dropped
    q = '{TAG_NEVER_USED, 8'h01, 8'h02};
    send_buffer(q, 0);

    // empty array and map, then a one-entry map
    q = '{TAG_FIXARRAY_BASE, TAG_FIXMAP_BASE};
    send_buffer(q, 0);
    q = '{TAG_FIXMAP_BASE | 8'd1, 8'h01, TAG_FIXSTR_BASE | 8'd1, 8'h41};
    send_buffer(q, 0);

    // nesting exactly at the limit passes
    q.delete();
    repeat (MAX_NESTING) q.push_back(TAG_FIXARRAY_BASE | 8'd1);
    q.push_back(8'h00);
    send_buffer(q, 0);
    // an empty container at the limit still passes
    q.delete();
    repeat (MAX_NESTING) q.push_back(TAG_FIXARRAY_BASE | 8'd1);
    q.push_back(TAG_FIXARRAY_BASE);
    send_buffer(q, 0);
    // one level too deep
    q.delete();
    repeat (MAX_NESTING + 1) q.push_back(TAG_FIXARRAY_BASE | 8'd1);
    q.push_back(8'h00);
    send_buffer(q, 0);

    // string length beyond the buffer
    q = '{TAG_STR8, 8'h05, 8'h41};
    send_buffer(q, 0);
    // length bytes themselves beyond the buffer
    q = '{TAG_ARRAY32, 8'h00};
    send_buffer(q, 0);
    // array count beyond the buffer
    q = '{TAG_ARRAY16, 8'h00, 8'h05, 8'h01};
    send_buffer(q, 0);
    // map count doubled beyond the buffer
    q = '{TAG_MAP16, 8'h00, 8'h02, 8'h01, 8'h02, 8'h03};
    send_buffer(q, 0);
    // fixarray count is not checked, buffer ends mid-array
    q = '{TAG_FIXARRAY_BASE | TAG_FIXCOL_LEN, 8'h01};
    send_buffer(q, 0);
    // buffer ends inside a number
    q = '{TAG_UINT16, 8'h01};
    send_buffer(q, 0);

    // largest bytes_left: a map count that only just fits, then the buffer ends
    send_byte(TAG_MAP32, '1);
    send_byte(8'h7f, '1);
    send_byte(8'hff, '1);
    send_byte(8'hff, '1);
    send_byte(8'hff, '1);
    send_byte(8'h00, '0);
    // doubled count one past the largest bytes_left; the last byte is dropped
    send_byte(TAG_MAP32, '1);
    send_byte(8'h80, '1);
    send_byte(8'h00, '1);
    send_byte(8'h00, '1);
    send_byte(8'h00, '1);
    send_byte(8'h00, '0);
  endtask

  initial begin
    rst                  = 1'b1;
    stream_ch.valid      = 1'b0;
    stream_ch.data_byte  = '0;
    stream_ch.bytes_left = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed_cases();

    // Random buffers: mostly well-formed objects, the rest cut short,
    // corrupted, left open into the next buffer, or plain noise. The idle
    // phase moves on every quarter of the walked bytes.
    base = walked;
    while (walked - base < RANDOM_BYTES) begin
      phase = (walked - base) * 4 / RANDOM_BYTES;
      if (phase > 3) phase = 3;
      buf_q.delete();
      extra = '0;
      mode  = $urandom_range(99, 0);
      if (mode < 88) begin
        repeat ($urandom_range(3, 1)) add_object(buf_q, 0);
      end else begin
        put_noise(buf_q, $urandom_range(8, 1));
      end

      if (mode >= 60 && mode < 72) begin
        // cut short
        n = $urandom_range(buf_q.size() - 1, 0);
        repeat (n) void'(buf_q.pop_back());
      end else if (mode >= 72 && mode < 82) begin
        // one byte replaced, often by the unused tag
        n = $urandom_range(buf_q.size() - 1, 0);
        buf_q[n] = chance(50) ? TAG_NEVER_USED : 8'($urandom_range(255, 0));
      end else if (mode >= 82 && mode < 88) begin
        // buffer claims far more bytes than it has; walk runs into the next one
        extra = $urandom_range(32'hffff_f000, 1);
      end
      send_buffer(buf_q, extra);
    end

    @(negedge clk);
    stream_ch.valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/mos_pkg.sv
src/mos_byte_if.sv
src/mos_result_if.sv
src/mos_tag_decode.sv
src/mos_level_stack.sv
src/mos_result_queue.sv
src/msgpack_object_skipper_core.sv
src/mos_checker.sv
verif/mos_tag_pkg.sv
verif/mos_skipper_checker.sv
verif/msgpack_object_skipper_core_test.sv
